[hdl/indexed_insert_erase_array_macros.svh]
// Assertion helpers used by the checker file.
`ifndef INDEXED_INSERT_ERASE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_ERASE_ARRAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IIEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iiea check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IIEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iiea check failed");

`endif

[hdl/iiea_pkg.sv]
package iiea_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int POS_W          = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_GET    = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cmd_t               command;
        logic [POS_W-1:0]   position;
        logic signed [31:0] value;
        logic [6:0]         count;
        logic               run_last;
    } request_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
        logic [7:0]         capacity_now;
        status_t            status;
    } result_t;

    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

[hdl/iiea_cell.sv]
module iiea_cell #(
    parameter int INDEX      = 0,
    parameter int WORD_WIDTH = iiea_pkg::WORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  iiea_pkg::cell_ctrl_t   ctrl,
    input  logic [WORD_WIDTH-1:0]  wdata,
    input  logic [WORD_WIDTH-1:0]  left_data,
    input  logic [WORD_WIDTH-1:0]  right_data,
    output logic [WORD_WIDTH-1:0]  data,
    output logic [WORD_WIDTH-1:0]  sel_data
);

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [WORD_WIDTH-1:0] data_reg;
    logic [WORD_WIDTH-1:0] data_next;
    logic [31:0]           pos32;
    logic                  at_pos;
    logic                  above_pos;

    assign pos32     = 32'(ctrl.pos);
    assign at_pos    = (IDX == pos32);
    assign above_pos = (IDX > pos32);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            iiea_pkg::OP_HOLD:
            begin
                data_next = data_reg;
            end
            iiea_pkg::OP_INSERT:
            begin
                if (above_pos)
                begin
                    data_next = left_data;
                end
                else if (at_pos)
                begin
                    data_next = wdata;
                end
            end
            iiea_pkg::OP_SHIFT:
            begin
                if (above_pos || at_pos)
                begin
                    data_next = right_data;
                end
            end
            iiea_pkg::OP_WRITE:
            begin
                if (at_pos)
                begin
                    data_next = wdata;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = at_pos ? data_reg : '0;

endmodule

[hdl/indexed_insert_erase_array.sv]
// channel   signals               beat accepted at
// request   start, busy, request  rising edge with start high and busy low
// result    done, result          rising edge ending the cycle done is high
//
// Insert, get and set do not raise busy; the result shows the cycle after accept.
// Erase of n entries (n after clamping) shifts the cell row left once per cycle
// and holds busy until n shifts are done; the result shows in the cycle busy drops.
// An erase that removes nothing gives its result the next cycle.
// Reset clears entry count to zero and capacity to one; entries are not cleared.
// Results cannot be stalled; a new request may be taken while one is shown.
module indexed_insert_erase_array #(
    parameter int DEPTH      = iiea_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = iiea_pkg::WORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  iiea_pkg::request_t request,
    output logic               done,
    output iiea_pkg::result_t  result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CAPW = CW + 1;

    logic [CW-1:0]               count_reg, count_next;
    logic [CAPW-1:0]             cap_reg, cap_next;
    logic [CW-1:0]               erase_left_reg, erase_left_next;
    logic [iiea_pkg::POS_W-1:0]  epos_reg, epos_next;
    logic                        done_reg, done_next;
    iiea_pkg::result_t           res_reg, res_next;

    iiea_pkg::cell_ctrl_t        ctrl;
    logic [WORD_WIDTH-1:0]       wdata;
    logic [WORD_WIDTH-1:0]       cell_data [DEPTH];
    logic [WORD_WIDTH-1:0]       cell_sel  [DEPTH];
    logic [WORD_WIDTH-1:0]       rd_or;
    logic signed [WORD_WIDTH-1:0] rd_word;
    logic signed [63:0]          rd_ext;
    logic signed [63:0]          val_ext;

    logic                        accept;
    logic [31:0]                 pos32, cnt32, ecnt32, avail32, n32;
    logic [CW-1:0]               count_inc;

    assign accept  = start && !busy;
    assign busy    = (erase_left_reg != '0);
    assign pos32   = 32'(request.position);
    assign cnt32   = 32'(count_reg);
    assign ecnt32  = 32'(request.count);
    assign avail32 = cnt32 - pos32;
    assign n32     = (ecnt32 < avail32) ? ecnt32 : avail32;
    assign count_inc = count_reg + CW'(1);

    assign val_ext = 64'(request.value);
    assign wdata   = val_ext[WORD_WIDTH-1:0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] left_in;
            logic [WORD_WIDTH-1:0] right_in;
            if (g == 0)
            begin : g_first
                assign left_in = cell_data[g];
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[g+1];
            end
            iiea_cell #(
                .INDEX      (g),
                .WORD_WIDTH (WORD_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .wdata      (wdata),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[g]),
                .sel_data   (cell_sel[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | cell_sel[i];
        end
    end

    assign rd_word = rd_or;
    assign rd_ext  = 64'(rd_word);

    // cell row control
    always_comb
    begin
        ctrl.op  = iiea_pkg::OP_HOLD;
        ctrl.pos = request.position;
        if (busy)
        begin
            ctrl.op  = iiea_pkg::OP_SHIFT;
            ctrl.pos = epos_reg;
        end
        else if (accept)
        begin
            unique case (request.command)
                iiea_pkg::CMD_INSERT:
                begin
                    if (pos32 <= cnt32 && cnt32 < 32'(DEPTH))
                    begin
                        ctrl.op = iiea_pkg::OP_INSERT;
                    end
                end
                iiea_pkg::CMD_SET:
                begin
                    if (pos32 < cnt32)
                    begin
                        ctrl.op = iiea_pkg::OP_WRITE;
                    end
                end
                iiea_pkg::CMD_ERASE,
                iiea_pkg::CMD_GET:
                begin
                    ctrl.op = iiea_pkg::OP_HOLD;
                end
                default:
                begin
                    ctrl.op = iiea_pkg::OP_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        cap_next        = cap_reg;
        erase_left_next = erase_left_reg;
        epos_next       = epos_reg;
        done_next       = 1'b0;
        res_next        = res_reg;

        if (busy)
        begin
            count_next      = count_reg - CW'(1);
            erase_left_next = erase_left_reg - CW'(1);
            if (erase_left_reg == CW'(1))
            begin
                done_next             = 1'b1;
                res_next.read_value   = '0;
                res_next.entry_count  = 7'(count_reg - CW'(1));
                res_next.capacity_now = 8'(cap_reg);
                res_next.status       = iiea_pkg::STATUS_DONE;
            end
        end
        else if (accept)
        begin
            res_next.read_value = '0;
            res_next.status     = iiea_pkg::STATUS_DONE;
            done_next           = 1'b1;
            unique case (request.command)
                iiea_pkg::CMD_INSERT:
                begin
                    if (pos32 > cnt32)
                    begin
                        res_next.status = iiea_pkg::STATUS_RANGE;
                    end
                    else if (cnt32 >= 32'(DEPTH))
                    begin
                        res_next.status = iiea_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_inc;
                        if (32'(cap_reg) == 32'(count_inc))
                        begin
                            cap_next = cap_reg << 1;
                        end
                    end
                end
                iiea_pkg::CMD_ERASE:
                begin
                    if (pos32 > cnt32)
                    begin
                        res_next.status = iiea_pkg::STATUS_RANGE;
                    end
                    else if (n32 != 32'd0)
                    begin
                        erase_left_next = CW'(n32);
                        epos_next       = request.position;
                        done_next       = 1'b0;
                    end
                end
                iiea_pkg::CMD_GET:
                begin
                    if (pos32 >= cnt32)
                    begin
                        res_next.status = iiea_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        res_next.read_value = rd_ext[31:0];
                    end
                end
                iiea_pkg::CMD_SET:
                begin
                    if (pos32 >= cnt32)
                    begin
                        res_next.status = iiea_pkg::STATUS_RANGE;
                    end
                end
                default:
                begin
                    res_next.status = iiea_pkg::STATUS_DONE;
                end
            endcase
            res_next.entry_count  = 7'(count_next);
            res_next.capacity_now = 8'(cap_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cap_reg        <= CAPW'(1);
            erase_left_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            erase_left_reg <= erase_left_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        epos_reg <= epos_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[hdl/iiea_checker.sv]
`include "indexed_insert_erase_array_macros.svh"

module iiea_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input iiea_pkg::request_t request,
    input logic               done,
    input iiea_pkg::result_t  result
);

    logic accept;
    logic req_seen;
    logic fail_beat;

    assign accept    = start && !busy;
    assign req_seen  = (request.command == iiea_pkg::CMD_ERASE) || !busy;
    assign fail_beat = done && (result.status != iiea_pkg::STATUS_DONE);

    `IIEA_ASSERT_IMP(a_done_not_busy, done, !busy)
    `IIEA_ASSERT_NXT(a_accept_answers, accept && req_seen, done || busy)
    `IIEA_ASSERT_IMP(a_erase_end_done, $fell(busy), done)
    `IIEA_ASSERT_IMP(a_fail_reads_zero, fail_beat, result.read_value == 0)

endmodule

bind indexed_insert_erase_array iiea_checker u_iiea_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
